// ===== rtl/assert_macros.svh =====
// Assertion shorthands; every property is clocked on clk and held off while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication violated");

// Consequent checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication violated");

// Condition that holds at every edge out of reset.
`define ASSERT_ALWAYS(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("invariant violated");

`endif

// ===== rtl/mscond_pkg.sv =====
package mscond_pkg;

	// samples per decimation window (1 to 64)
	localparam int RATIO = 8;
	localparam int WIN_W = $clog2(RATIO + 1);

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

	localparam int SUM_W = 23;

	localparam int REG_COUNT = 4;
	localparam int REG_IDX_W = $clog2(REG_COUNT);
	localparam int ADDR_W = REG_IDX_W + 2;

	// field = trunc(counts * 1600 / lsb_per_gauss), done as |counts| * M >> FIELD_SHIFT
	// with M = ceil(1600 * 2^FIELD_SHIFT / lsb). Exact since |counts| * (M*lsb - 1600*2^S)
	// stays below 2^15 * 2^13 = 2^FIELD_SHIFT.
	localparam int FIELD_SHIFT = 28;
	localparam int FIELD_MUL_W = 28;
	localparam int FIELD_PROD_W = 16 + FIELD_MUL_W;
	localparam longint UT16_PER_GAUSS = 1600;
	localparam longint FIELD_NUM = UT16_PER_GAUSS << FIELD_SHIFT;
	localparam longint LSB_4G = 6842;
	localparam longint LSB_8G = 3421;
	localparam longint LSB_12G = 2281;
	localparam longint LSB_16G = 1711;
	localparam logic [FIELD_MUL_W-1:0] FIELD_MUL_4G =
		FIELD_MUL_W'((FIELD_NUM + LSB_4G - 1) / LSB_4G);
	localparam logic [FIELD_MUL_W-1:0] FIELD_MUL_8G =
		FIELD_MUL_W'((FIELD_NUM + LSB_8G - 1) / LSB_8G);
	localparam logic [FIELD_MUL_W-1:0] FIELD_MUL_12G =
		FIELD_MUL_W'((FIELD_NUM + LSB_12G - 1) / LSB_12G);
	localparam logic [FIELD_MUL_W-1:0] FIELD_MUL_16G =
		FIELD_MUL_W'((FIELD_NUM + LSB_16G - 1) / LSB_16G);

	// window average: |sum| * ceil(2^AVG_SHIFT / RATIO) >> AVG_SHIFT, exact for |sum| < 2^22
	localparam int AVG_SHIFT = 28;
	localparam int AVG_MUL_W = AVG_SHIFT + 1;
	localparam longint AVG_NUM = longint'(1) << AVG_SHIFT;
	localparam logic [AVG_MUL_W-1:0] AVG_MUL =
		AVG_MUL_W'((AVG_NUM + longint'(RATIO) - 1) / longint'(RATIO));
	localparam int AVG_PROD_W = SUM_W + AVG_MUL_W;

	typedef enum logic [1:0] {
		SCALE_4G  = 2'd0,
		SCALE_8G  = 2'd1,
		SCALE_12G = 2'd2,
		SCALE_16G = 2'd3
	} scale_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_OFFSET_X     = REG_IDX_W'(0),
		REG_OFFSET_Y     = REG_IDX_W'(1),
		REG_OFFSET_Z     = REG_IDX_W'(2),
		REG_SCALE_SELECT = REG_IDX_W'(3)
	} reg_idx_t;

	typedef struct packed {
		logic signed [15:0] sample_x;
		logic signed [15:0] sample_y;
		logic signed [15:0] sample_z;
	} sample_t;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
	} fast_t;

	typedef struct packed {
		logic signed [15:0] fast_x;
		logic signed [15:0] fast_y;
		logic signed [15:0] fast_z;
		logic signed [15:0] smooth_x;
		logic signed [15:0] smooth_y;
		logic signed [15:0] smooth_z;
		logic signed [15:0] avg_x;
		logic signed [15:0] avg_y;
		logic signed [15:0] avg_z;
		logic               avg_valid;
	} result_t;

	function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
		logic signed [15:0] r;
		if (v > 17'sd32767)
			r = 16'sh7fff;
		else if (v < -17'sd32768)
			r = 16'sh8000;
		else
			r = v[15:0];
		return r;
	endfunction

	function automatic logic [FIELD_MUL_W-1:0] field_scale(input scale_t sel);
		logic [FIELD_MUL_W-1:0] m;
		case (sel)
			SCALE_4G:  m = FIELD_MUL_4G;
			SCALE_8G:  m = FIELD_MUL_8G;
			SCALE_12G: m = FIELD_MUL_12G;
			SCALE_16G: m = FIELD_MUL_16G;
			default:   m = FIELD_MUL_4G;
		endcase
		return m;
	endfunction

endpackage

// ===== rtl/mscond_front.sv =====
module mscond_front import mscond_pkg::*; (
	input  logic               sample_valid,
	output logic               sample_ready,
	input  sample_t            sample,
	input  logic signed [15:0] offset_x,
	input  logic signed [15:0] offset_y,
	input  logic signed [15:0] offset_z,
	output logic               push_valid,
	input  logic               push_ready,
	output fast_t              push_data
);

	logic signed [15:0] corr_x;
	logic signed [15:0] corr_y;

	always_comb begin
		corr_x = sat16({sample.sample_x[15], sample.sample_x} - {offset_x[15], offset_x});
		corr_y = sat16({sample.sample_y[15], sample.sample_y} - {offset_y[15], offset_y});
		// axis swap: x' = -(y - off_y), y' = -(x - off_x)
		push_data.x = sat16(17'sd0 - {corr_y[15], corr_y});
		push_data.y = sat16(17'sd0 - {corr_x[15], corr_x});
		push_data.z = sat16({sample.sample_z[15], sample.sample_z} - {offset_z[15], offset_z});
	end

	assign push_valid = sample_valid;
	assign sample_ready = push_ready;

endmodule

// ===== rtl/mscond_queue.sv =====
module mscond_queue import mscond_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_valid,
	output logic  push_ready,
	input  fast_t push_data,
	output logic  pop_valid,
	input  logic  pop_ready,
	output fast_t pop_data
);

	fast_t mem [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;
	logic push;
	logic pop;

	assign push_ready = (count_q != (QUEUE_AW + 1)'(QUEUE_DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_data = mem[rd_ptr_q];
	assign push = push_valid && push_ready;
	assign pop = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem[wr_ptr_q] <= push_data;
	end

endmodule

// ===== rtl/mscond_back.sv =====
module mscond_back import mscond_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    pop_valid,
	output logic    pop_ready,
	input  fast_t   pop_data,
	input  scale_t  scale_select,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result
);

	logic signed [15:0]      axis [3];
	logic [15:0]             axis_mag [3];
	logic signed [SUM_W-1:0] sum_next [3];
	logic [FIELD_MUL_W-1:0]  field_mul;
	logic                    window_end;
	logic                    advance;
	logic                    load;

	// stage 1: scaled magnitude product, window sum
	logic                    valid_s1;
	logic [FIELD_PROD_W-1:0] prod_s1 [3];
	logic                    neg_s1 [3];
	logic signed [15:0]      fast_s1 [3];
	logic signed [SUM_W-1:0] sum_s1 [3];
	logic                    end_s1;

	logic signed [SUM_W-1:0] sums_q [3];
	logic [WIN_W-1:0]        win_q;
	logic signed [15:0]      smooth_q [3];

	logic [15:0]             field_mag [3];
	logic signed [15:0]      field [3];
	logic signed [16:0]      smooth_sum [3];
	logic signed [15:0]      smooth_next [3];
	logic [SUM_W-1:0]        sum_mag [3];
	logic [AVG_PROD_W-1:0]   avg_prod [3];
	logic [16:0]             avg_mag [3];
	logic signed [15:0]      avg_next [3];

	logic    valid_s2;
	result_t result_s2;

	assign advance = !valid_s2 || result_ready;
	assign pop_ready = !valid_s1 || advance;
	assign load = pop_valid && pop_ready;
	assign window_end = (win_q == WIN_W'(RATIO - 1));
	assign field_mul = field_scale(scale_select);

	always_comb begin
		axis[0] = pop_data.x;
		axis[1] = pop_data.y;
		axis[2] = pop_data.z;
		for (int i = 0; i < 3; i++) begin
			axis_mag[i] = axis[i][15] ? 16'(~axis[i] + 16'sd1) : 16'(axis[i]);
			sum_next[i] = sums_q[i] + SUM_W'(axis[i]);
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			field_mag[i] = prod_s1[i][FIELD_SHIFT +: 16];
			field[i] = neg_s1[i] ? 16'(~field_mag[i] + 16'd1) : field_mag[i];
			// arithmetic shift: rounds toward minus infinity
			smooth_sum[i] = {smooth_q[i][15], smooth_q[i]} + {field[i][15], field[i]};
			smooth_next[i] = smooth_sum[i][16:1];
			sum_mag[i] = sum_s1[i][SUM_W-1] ? SUM_W'(~sum_s1[i] + 1'b1) : SUM_W'(sum_s1[i]);
			avg_prod[i] = AVG_PROD_W'(sum_mag[i]) * AVG_PROD_W'(AVG_MUL);
			avg_mag[i] = avg_prod[i][AVG_SHIFT +: 17];
			if (!end_s1)
				avg_next[i] = '0;
			else if (sum_s1[i][SUM_W-1])
				avg_next[i] = 16'(~avg_mag[i] + 17'd1);
			else
				avg_next[i] = avg_mag[i][15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			win_q <= '0;
			for (int i = 0; i < 3; i++) begin
				sums_q[i] <= '0;
				smooth_q[i] <= '0;
			end
		end else begin
			if (pop_ready)
				valid_s1 <= pop_valid;
			if (load) begin
				win_q <= window_end ? '0 : win_q + 1'b1;
				for (int i = 0; i < 3; i++)
					sums_q[i] <= window_end ? '0 : sum_next[i];
			end
			if (advance) begin
				valid_s2 <= valid_s1;
				if (valid_s1) begin
					for (int i = 0; i < 3; i++)
						smooth_q[i] <= smooth_next[i];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			end_s1 <= window_end;
			for (int i = 0; i < 3; i++) begin
				prod_s1[i] <= FIELD_PROD_W'(axis_mag[i]) * FIELD_PROD_W'(field_mul);
				neg_s1[i] <= axis[i][15];
				fast_s1[i] <= axis[i];
				sum_s1[i] <= sum_next[i];
			end
		end
		if (advance && valid_s1) begin
			result_s2.fast_x <= fast_s1[0];
			result_s2.fast_y <= fast_s1[1];
			result_s2.fast_z <= fast_s1[2];
			result_s2.smooth_x <= smooth_next[0];
			result_s2.smooth_y <= smooth_next[1];
			result_s2.smooth_z <= smooth_next[2];
			result_s2.avg_x <= avg_next[0];
			result_s2.avg_y <= avg_next[1];
			result_s2.avg_z <= avg_next[2];
			result_s2.avg_valid <= end_s1;
		end
	end

	assign result_valid = valid_s2;
	assign result = result_s2;

endmodule

// ===== rtl/magnetometer_sample_conditioner.sv =====
// Magnetometer sample conditioner. Each accepted request (one raw x/y/z sample)
// gives exactly one result: offset-corrected, axis-swapped counts (fast_*),
// a half-weight exponential average of the field in 1/16 uT (smooth_*), and,
// on every RATIO-th sample, the truncated window average with avg_valid set
// (avg_* read zero otherwise). Sustained rate is one request per clock while
// result_ready is high. The front end corrects and remaps the sample in the
// accept cycle and writes it to a four-entry queue; the back end runs a
// two-stage pipeline (field scaling multiply, then filter and window average
// into the output register), so a stalled output fills the queue before
// sample_ready drops. Registers sit on the APB port at 0x0 offset_x, 0x4
// offset_y, 0x8 offset_z, 0xC scale_select; write them only while no
// request is in flight.
module magnetometer_sample_conditioner import mscond_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sample_valid,
	output logic              sample_ready,
	input  sample_t           sample,
	output logic              result_valid,
	input  logic              result_ready,
	output result_t           result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	logic signed [15:0] offset_x_q;
	logic signed [15:0] offset_y_q;
	logic signed [15:0] offset_z_q;
	scale_t             scale_q;
	reg_idx_t           reg_idx;
	logic               cfg_write;

	logic  push_valid;
	logic  push_ready;
	fast_t push_data;
	logic  pop_valid;
	logic  pop_ready;
	fast_t pop_data;

	assign pready = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign cfg_write = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_x_q <= '0;
			offset_y_q <= '0;
			offset_z_q <= '0;
			scale_q <= SCALE_4G;
		end else if (cfg_write) begin
			case (reg_idx)
				REG_OFFSET_X:     offset_x_q <= pwdata[15:0];
				REG_OFFSET_Y:     offset_y_q <= pwdata[15:0];
				REG_OFFSET_Z:     offset_z_q <= pwdata[15:0];
				REG_SCALE_SELECT: scale_q <= scale_t'(pwdata[1:0]);
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_OFFSET_X:     prdata = 32'(offset_x_q);
			REG_OFFSET_Y:     prdata = 32'(offset_y_q);
			REG_OFFSET_Z:     prdata = 32'(offset_z_q);
			REG_SCALE_SELECT: prdata = 32'(scale_q);
			default:          prdata = '0;
		endcase
	end

	mscond_front u_front (
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.offset_x     (offset_x_q),
		.offset_y     (offset_y_q),
		.offset_z     (offset_z_q),
		.push_valid   (push_valid),
		.push_ready   (push_ready),
		.push_data    (push_data)
	);

	mscond_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	mscond_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop_valid    (pop_valid),
		.pop_ready    (pop_ready),
		.pop_data     (pop_data),
		.scale_select (scale_q),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

// ===== rtl/mscond_checker.sv =====
`include "assert_macros.svh"

module mscond_checker import mscond_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    result_valid,
	input logic    result_ready,
	input result_t result,
	input logic    pready
);

	// a stalled result stays put
	`ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result))

	// averages only show on a window end
	`ASSERT_IMPLIES(a_avg_zero_off_window, result_valid && !result.avg_valid, result.avg_x == 16'sd0 && result.avg_y == 16'sd0 && result.avg_z == 16'sd0)

	// negated axes saturate at +32767, so they never reach the most negative code
	`ASSERT_IMPLIES(a_swapped_axes_no_min, result_valid, result.fast_x != 16'sh8000 && result.fast_y != 16'sh8000)

	`ASSERT_ALWAYS(a_pready_high, pready)

endmodule

bind magnetometer_sample_conditioner mscond_checker u_checker (.*);

// ===== bench/tb_magnetometer_sample_conditioner.sv =====
`timescale 1ns / 100ps

module tb_magnetometer_sample_conditioner;
	import mscond_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_PER_PHASE = 150;
	localparam int PHASES = 6;

	class conditioner_scoreboard;
		logic signed [15:0] offset_x, offset_y, offset_z;
		scale_t scale;
		int axis_sums[3];
		int window_count;
		int smoothed[3];
		result_t expected_results[$];
		int errors;
		int checked;
		int windows_closed;

		function new();
			offset_x = '0;
			offset_y = '0;
			offset_z = '0;
			scale = SCALE_4G;
			foreach (axis_sums[i]) begin
				axis_sums[i] = 0;
				smoothed[i] = 0;
			end
			window_count = 0;
			errors = 0;
			checked = 0;
			windows_closed = 0;
		endfunction

		function void set_register(reg_idx_t idx, logic [31:0] data);
			case (idx)
				REG_OFFSET_X:     offset_x = data[15:0];
				REG_OFFSET_Y:     offset_y = data[15:0];
				REG_OFFSET_Z:     offset_z = data[15:0];
				REG_SCALE_SELECT: scale = scale_t'(data[1:0]);
				default: ;
			endcase
		endfunction

		function int clamp16(int v);
			if (v > 32767)
				return 32767;
			if (v < -32768)
				return -32768;
			return v;
		endfunction

		function int counts_per_gauss(scale_t sc);
			case (sc)
				SCALE_4G:  return 6842;
				SCALE_8G:  return 3421;
				SCALE_12G: return 2281;
				default:   return 1711;
			endcase
		endfunction

		// corrected counts, field filter and window sums for one accepted request
		function void note_sample(sample_t s);
			int cor[3];
			int avg[3];
			int field;
			int lsb;
			result_t r;
			lsb = counts_per_gauss(scale);
			cor[0] = clamp16(-clamp16(int'(s.sample_y) - int'(offset_y)));
			cor[1] = clamp16(-clamp16(int'(s.sample_x) - int'(offset_x)));
			cor[2] = clamp16(int'(s.sample_z) - int'(offset_z));
			for (int i = 0; i < 3; i++) begin
				field = (cor[i] * 1600) / lsb;
				axis_sums[i] += cor[i];
				smoothed[i] = (smoothed[i] + field) >>> 1;
				avg[i] = 0;
			end
			window_count++;
			r.avg_valid = 1'b0;
			if (window_count >= RATIO) begin
				for (int i = 0; i < 3; i++) begin
					avg[i] = clamp16(axis_sums[i] / RATIO);
					axis_sums[i] = 0;
				end
				window_count = 0;
				r.avg_valid = 1'b1;
				windows_closed++;
			end
			r.fast_x = 16'(cor[0]);
			r.fast_y = 16'(cor[1]);
			r.fast_z = 16'(cor[2]);
			r.smooth_x = 16'(smoothed[0]);
			r.smooth_y = 16'(smoothed[1]);
			r.smooth_z = 16'(smoothed[2]);
			r.avg_x = 16'(avg[0]);
			r.avg_y = 16'(avg[1]);
			r.avg_z = 16'(avg[2]);
			expected_results.push_back(r);
		endfunction

		function void compare_field(string name, int want, int got);
			if (want != got) begin
				errors++;
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			end
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (expected_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, none pending, actual %h", $time, got);
				return;
			end
			want = expected_results.pop_front();
			checked++;
			compare_field("fast_x", int'(want.fast_x), int'(got.fast_x));
			compare_field("fast_y", int'(want.fast_y), int'(got.fast_y));
			compare_field("fast_z", int'(want.fast_z), int'(got.fast_z));
			compare_field("smooth_x", int'(want.smooth_x), int'(got.smooth_x));
			compare_field("smooth_y", int'(want.smooth_y), int'(got.smooth_y));
			compare_field("smooth_z", int'(want.smooth_z), int'(got.smooth_z));
			compare_field("avg_x", int'(want.avg_x), int'(got.avg_x));
			compare_field("avg_y", int'(want.avg_y), int'(got.avg_y));
			compare_field("avg_z", int'(want.avg_z), int'(got.avg_z));
			compare_field("avg_valid", int'(want.avg_valid), int'(got.avg_valid));
		endfunction

		function int pending();
			return expected_results.size();
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              sample_valid;
	logic              sample_ready;
	sample_t           sample;
	logic              result_valid;
	logic              result_ready;
	result_t           result;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;

	conditioner_scoreboard sb;
	int  cycle_count = 0;
	int  hold_off_cycles = 0;
	bit  gaps_on = 1'b0;
	int  settings_used = 0;

	magnetometer_sample_conditioner DUT (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.sample(sample),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d results still pending", $time, sb.pending());
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic logic [15:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 16'h7fff;
			1: return 16'h8000;
			2: return 16'h0000;
			3: return 16'($urandom_range(0, 15)) - 16'd8;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic write_register(input reg_idx_t idx, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.set_register(idx, data);
		@(posedge clk);
	endtask

	// upper bits carry junk, the block must ignore them
	task automatic configure(input logic [15:0] ox, input logic [15:0] oy,
			input logic [15:0] oz, input scale_t sc);
		write_register(REG_OFFSET_X, {16'($urandom), ox});
		write_register(REG_OFFSET_Y, {16'($urandom), oy});
		write_register(REG_OFFSET_Z, {16'($urandom), oz});
		write_register(REG_SCALE_SELECT, {30'($urandom), sc});
	endtask

	task automatic send_sample(input sample_t s);
		int gap;
		gap = gaps_on ? $urandom_range(0, 6) : 0;
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_valid <= 1'b1;
		sample <= s;
		do @(posedge clk); while (!sample_ready);
		sb.note_sample(s);
	endtask

	task automatic drain();
		sample_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// result side: random stalls per request, plus one long hold-off on demand
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			if (hold_off_cycles > 0) begin
				stall = hold_off_cycles;
				hold_off_cycles = 0;
			end else begin
				stall = gaps_on ? $urandom_range(0, 6) : 0;
			end
			if (stall > 0) begin
				result_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ready <= 1'b1;
			do @(posedge clk); while (!result_valid);
			sb.check_result(result);
		end
	end

	initial begin
		sample_t directed[12];
		sample_t extremes[4];
		bit pressure;
		directed[0]  = {16'h7fff, 16'h8000, 16'h7fff};
		directed[1]  = {16'h8000, 16'h7fff, 16'h8000};
		directed[2]  = {16'h0000, 16'h0000, 16'h0000};
		directed[3]  = {16'hffff, 16'hffff, 16'hffff};
		directed[4]  = {16'h0001, 16'hffff, 16'hfffe};
		directed[5]  = {16'hfffd, 16'h0003, 16'hfffb};
		directed[6]  = {16'h8000, 16'h8000, 16'h8000};
		directed[7]  = {16'h0005, 16'hfffa, 16'h0002};
		directed[8]  = {16'h7fff, 16'h7fff, 16'h7fff};
		directed[9]  = {16'h5555, 16'haaaa, 16'h5555};
		directed[10] = {16'haaaa, 16'h5555, 16'haaaa};
		directed[11] = {16'hffff, 16'h0001, 16'h8001};
		extremes[0] = {16'h7fff, 16'h7fff, 16'h7fff};
		extremes[1] = {16'h8000, 16'h8000, 16'h8000};
		extremes[2] = {16'h7fff, 16'h8000, 16'h0000};
		extremes[3] = {16'h8000, 16'h7fff, 16'hffff};

		arst_n = 1'b0;
		sample_valid = 1'b0;
		sample = '0;
		result_ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		sb = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				1: configure(16'h7fff, 16'h8000, 16'h8000, SCALE_16G);
				2: configure(16'h8000, 16'h7fff, 16'h7fff, SCALE_8G);
				3: configure(pick_value(), pick_value(), pick_value(), SCALE_12G);
				4: configure(pick_value(), pick_value(), pick_value(),
						scale_t'($urandom_range(0, 3)));
				5: configure(16'h0000, 16'h0000, 16'h0000, SCALE_4G);
				default: ;
			endcase
			settings_used++;
			pressure = (p == 2);
			gaps_on = 1'b0;
			if (p == 0)
				foreach (directed[i])
					send_sample(directed[i]);
			if (p == 1 || p == 2)
				foreach (extremes[i])
					send_sample(extremes[i]);
			// back-to-back requests against a stalled output fill the queue
			if (pressure)
				hold_off_cycles = 80;
			for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
				if (k % 40 == 0)
					gaps_on = !pressure && ($urandom_range(0, 3) != 0);
				send_sample(sample_t'({pick_value(), pick_value(), pick_value()}));
			end
			drain();
		end

		$display("Checked %0d results over %0d register settings, %0d averaging windows closed.",
			sb.checked, settings_used, sb.windows_closed);
		$display("Covered offset and negation saturation, all four full scales and output stalls.");
		if (sb.errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/mscond_pkg.sv
rtl/mscond_front.sv
rtl/mscond_queue.sv
rtl/mscond_back.sv
rtl/magnetometer_sample_conditioner.sv
rtl/mscond_checker.sv
bench/tb_magnetometer_sample_conditioner.sv
